@@ rtl/core/ppu_pkg.sv @@
// Shared types and constants for the pivot partition unit.
// Used by the controller, the datapath and the top level.
`default_nettype none

package ppu_pkg;

    localparam int PPU_MAX_ELEMENTS = 64;
    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 7;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    // register index is paddr[2]
    localparam logic REG_PIVOT = 1'b0;

    typedef enum logic [8:0] {
        S_LOAD      = 9'b000000001,
        S_LEFT_RD   = 9'b000000010,
        S_LEFT_CMP  = 9'b000000100,
        S_RIGHT_RD  = 9'b000001000,
        S_RIGHT_CMP = 9'b000010000,
        S_SWAP_A    = 9'b000100000,
        S_SWAP_B    = 9'b001000000,
        S_EMIT_RD   = 9'b010000000,
        S_EMIT_WR   = 9'b100000000
    } ppu_state_t;

    typedef struct packed {
        logic load_write;
        logic load_start;
        logic left_read;
        logic left_advance;
        logic left_hold;
        logic right_read;
        logic right_step;
        logic right_hold;
        logic swap_a;
        logic swap_b;
        logic emit_read;
        logic emit_load;
        logic emit_done;
    } ppu_cmd_t;

    typedef struct packed {
        logic i_lt_n;
        logic j_gt_0;
        logic i_lt_j;
        logic rd_le_pivot;
        logic k_last;
        logic out_free;
    } ppu_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/ppu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ppu_ctrl.sv @@
// Sequencer for load, two-index partition walk and emit pass.
// Depends on ppu_pkg; drives the datapath through ppu_cmd_t.
`default_nettype none

module ppu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    input  wire logic              last_element,
    output logic                   load_ready,
    input  wire ppu_pkg::ppu_sts_t sts,
    output ppu_pkg::ppu_cmd_t      cmd
);

    import ppu_pkg::*;

    ppu_state_t state_reg;
    ppu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign load_ready = (state_reg == S_LOAD);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (load_valid)
                begin
                    cmd.load_write = 1'b1;
                    // the last request is stored too unless the store is full, so the set is never empty
                    if (last_element)
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = S_LEFT_RD;
                    end
                end
            end
            S_LEFT_RD:
            begin
                if (sts.i_lt_n)
                begin
                    cmd.left_read = 1'b1;
                    state_next    = S_LEFT_CMP;
                end
                else
                begin
                    state_next = S_RIGHT_RD;
                end
            end
            S_LEFT_CMP:
            begin
                if (sts.rd_le_pivot)
                begin
                    cmd.left_advance = 1'b1;
                    state_next       = S_LEFT_RD;
                end
                else
                begin
                    cmd.left_hold = 1'b1;
                    state_next    = S_RIGHT_RD;
                end
            end
            S_RIGHT_RD:
            begin
                if (sts.j_gt_0)
                begin
                    cmd.right_read = 1'b1;
                    state_next     = S_RIGHT_CMP;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_RIGHT_CMP:
            begin
                if (!sts.rd_le_pivot)
                begin
                    cmd.right_step = 1'b1;
                    state_next     = S_RIGHT_RD;
                end
                else
                begin
                    cmd.right_hold = 1'b1;
                    state_next     = sts.i_lt_j ? S_SWAP_A : S_EMIT_RD;
                end
            end
            S_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                state_next = S_LEFT_RD;
            end
            S_EMIT_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                cmd.emit_load = 1'b1;
                if (sts.k_last)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_LOAD;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/ppu_datapath.sv @@
// Element store, walk indices, compare and result register.
// Depends on ppu_pkg and ppu_ram; commanded by ppu_ctrl.
`default_nettype none

module ppu_datapath #(
    parameter int MAX_ELEMENTS = ppu_pkg::PPU_MAX_ELEMENTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ppu_pkg::ppu_cmd_t           cmd,
    output ppu_pkg::ppu_sts_t                sts,
    input  wire logic [ppu_pkg::DATA_W-1:0]  element,
    input  wire logic [ppu_pkg::DATA_W-1:0]  pivot,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic      [ppu_pkg::DATA_W-1:0]  element_out,
    output logic                             in_lower_part,
    output logic      [ppu_pkg::COUNT_W-1:0] lower_count,
    output logic                             last_out
);

    import ppu_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);

    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [DATA_W-1:0] ei_reg;
    logic [DATA_W-1:0] ej_reg;
    logic              full;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              result_valid_reg;
    logic [DATA_W-1:0] element_out_reg;
    logic              in_lower_reg;
    logic [COUNT_W-1:0] lower_count_reg;
    logic              last_out_reg;

    assign full      = (fill_reg == CNT_W'(MAX_ELEMENTS));
    assign fill_next = full ? fill_reg : fill_reg + CNT_W'(1);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fill_reg[IDX_W-1:0];
        ram_wdata = element;
        if (cmd.load_write)
        begin
            ram_we = !full;
        end
        else if (cmd.swap_a)
        begin
            ram_we    = 1'b1;
            ram_waddr = i_reg[IDX_W-1:0];
            ram_wdata = ej_reg;
        end
        else if (cmd.swap_b)
        begin
            ram_we    = 1'b1;
            ram_waddr = j_reg;
            ram_wdata = ei_reg;
        end
    end

    assign ram_re = cmd.left_read | cmd.right_read | cmd.emit_read;

    always_comb
    begin
        ram_raddr = k_reg;
        if (cmd.left_read)
        begin
            ram_raddr = i_reg[IDX_W-1:0];
        end
        else if (cmd.right_read)
        begin
            ram_raddr = j_reg;
        end
    end

    ppu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (cmd.load_write)
            begin
                fill_reg <= fill_next;
            end
            else if (cmd.emit_done)
            begin
                fill_reg <= '0;
            end

            if (cmd.load_start)
            begin
                i_reg <= '0;
                j_reg <= IDX_W'(fill_next - CNT_W'(1));
            end
            else if (cmd.left_advance || cmd.swap_b)
            begin
                i_reg <= i_reg + CNT_W'(1);
            end

            if (cmd.right_step || cmd.swap_b)
            begin
                j_reg <= j_reg - IDX_W'(1);
            end

            if (cmd.load_start || cmd.emit_done)
            begin
                k_reg <= '0;
            end
            else if (cmd.emit_load)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.left_hold)
        begin
            ei_reg <= ram_rdata;
        end
        if (cmd.right_hold)
        begin
            ej_reg <= ram_rdata;
        end
    end

    // result register: decouples the emit pass from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            element_out_reg <= ram_rdata;
            in_lower_reg    <= (CNT_W'(k_reg) < i_reg);
            lower_count_reg <= COUNT_W'(i_reg);
            last_out_reg    <= sts.k_last;
        end
    end

    assign sts.i_lt_n      = (i_reg < fill_reg);
    assign sts.j_gt_0      = (j_reg != '0);
    assign sts.i_lt_j      = (i_reg < CNT_W'(j_reg));
    assign sts.rd_le_pivot = ($signed(ram_rdata) <= $signed(pivot));
    assign sts.k_last      = ((CNT_W'(k_reg) + CNT_W'(1)) == fill_reg);
    assign sts.out_free    = !result_valid_reg || result_ready;

    assign result_valid  = result_valid_reg;
    assign element_out   = element_out_reg;
    assign in_lower_part = in_lower_reg;
    assign lower_count   = lower_count_reg;
    assign last_out      = last_out_reg;

endmodule

`default_nettype wire

@@ rtl/core/pivot_partition_unit.sv @@
// Top level of the pivot partition unit: APB pivot register, controller, datapath.
// Depends on ppu_pkg, ppu_ctrl, ppu_datapath (which holds a ppu_ram store).
`default_nettype none

// Loads signed 32-bit elements, one request per cycle, until a request with
// last_element set; elements beyond MAX_ELEMENTS are dropped. The set is then
// partitioned in place around the pivot register (elements <= pivot first) by
// a two-index walk over a single-port-read store, and every element is sent
// out in its new order with its lower-part flag and the size of that part.
// The walk reads and then compares one element per index step and writes
// both elements of a swap in turn, paced by the one read port of the store
// and its registered read; the emit pass reads each element, then loads it
// into the output register once free. Loading is blocked from the last
// request until the final result has entered the output register; that
// register may still hold a result while the next set loads.
module pivot_partition_unit #(
    parameter int MAX_ELEMENTS = ppu_pkg::PPU_MAX_ELEMENTS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ppu_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [ppu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [ppu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,

    input  wire logic                            load_valid,
    output logic                                 load_ready,
    input  wire logic [ppu_pkg::DATA_W-1:0]      element,
    input  wire logic                            last_element,

    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic      [ppu_pkg::DATA_W-1:0]      element_out,
    output logic                                 in_lower_part,
    output logic      [ppu_pkg::COUNT_W-1:0]     lower_count,
    output logic                                 last_out
);

    import ppu_pkg::*;

    logic [DATA_W-1:0] pivot_reg;
    logic              cfg_write;
    ppu_cmd_t          cmd;
    ppu_sts_t          sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_PIVOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg <= '0;
        end
        else if (cfg_write)
        begin
            pivot_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_PIVOT) ? pivot_reg : '0;

    ppu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .last_element (last_element),
        .load_ready   (load_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    ppu_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .element       (element),
        .pivot         (pivot_reg),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .element_out   (element_out),
        .in_lower_part (in_lower_part),
        .lower_count   (lower_count),
        .last_out      (last_out)
    );

`ifndef ASSERT_OFF
    // a position flagged lower means the lower part is not empty
    a_lower_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && in_lower_part |-> lower_count != '0)
        else $error("lower flag with empty lower part");

    // a position outside the lower part means the lower part is not the whole store
    a_upper_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_lower_part |-> lower_count < COUNT_W'(MAX_ELEMENTS))
        else $error("upper position with full lower part");

    // loading stops once the final element of a set is taken
    a_load_stops: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && load_ready && last_element |=> !load_ready)
        else $error("load still open after last element");
`endif

endmodule

`default_nettype wire
